/* rtl/core/srsw_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srsw_pkg
// Types and fixed constants of the selective-repeat sender window block.
// ----------------------------------------------------------------------------
package srsw_pkg;

   localparam int SEQ_W     = 17;
   localparam int TIMER_W   = 9;
   localparam int WSIZE_W   = 6;
   localparam int TIMEOUT_W = 8;
   localparam int TOTAL_W   = 16;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DAT_W = 16;

   // slot timer codes: zero is unsent or expired, all ones is acked
   localparam logic [TIMER_W-1:0] TIMER_IDLE  = '0;
   localparam logic [TIMER_W-1:0] TIMER_ACKED = '1;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_WINDOW_SIZE   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TIMEOUT_TICKS = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_TOTAL_PACKETS = 2'd2;

   // reset values of the registers
   localparam logic [WSIZE_W-1:0]   WINDOW_SIZE_RST   = 6'd4;
   localparam logic [TIMEOUT_W-1:0] TIMEOUT_TICKS_RST = 8'd8;
   localparam logic [TOTAL_W-1:0]   TOTAL_PACKETS_RST = 16'd1;

   localparam logic CMD_TICK = 1'b0;
   localparam logic CMD_ACK  = 1'b1;

   localparam logic KIND_SEND   = 1'b0;
   localparam logic KIND_STATUS = 1'b1;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_DISPATCH,
      ST_ACK_CHECK,
      ST_TICK_READ,
      ST_TICK_EVAL,
      ST_SLIDE_READ,
      ST_SLIDE_EVAL,
      ST_STATUS
   } state_type;

endpackage

/* rtl/core/srsw_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srsw_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module srsw_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/core/selective_repeat_sender_window_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// selective_repeat_sender_window_top
// Selective-repeat ARQ sender window: per-slot retransmit timers, send
// requests on each tick, ack marking and base sliding.
// ----------------------------------------------------------------------------
// One item at a time. The slot timers sit in a RAM with a registered read, so
// each slot visited takes a read state, then an update state (TICK_READ then
// TICK_EVAL on a tick, SLIDE_READ then SLIDE_EVAL as the base slides); a
// stalled result port can hold an item. After reset the block runs a clearing
// pass over every slot of the timer RAM and accepts no item until it is done;
// register writes are always taken. Every item ends with one status transfer
// flagged last.
// ----------------------------------------------------------------------------
module selective_repeat_sender_window_top #(
   parameter int WINDOW_MAX = 32,
   parameter int RING_SLOTS = 64
) (
   input  logic                            clock,
   input  logic                            reset,
   // request channel
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic                            req_command,
   input  logic [srsw_pkg::SEQ_W-1:0]      req_ack_seq,
   input  logic                            req_ack_good,
   // response channel
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic                            rsp_kind,
   output logic [srsw_pkg::SEQ_W-1:0]      rsp_seq_num,
   output logic [srsw_pkg::SEQ_W-1:0]      rsp_window_base,
   output logic                            rsp_finished,
   output logic                            rsp_last,
   // register write channel
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [srsw_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [srsw_pkg::CSR_DAT_W-1:0]  csr_wdata
);

   localparam int WIN_LIM = (WINDOW_MAX < RING_SLOTS) ? WINDOW_MAX : RING_SLOTS;
   localparam int SLOT_W  = $clog2(RING_SLOTS);
   localparam int CNT_W   = $clog2(WIN_LIM + 1);
   localparam int N_W     = $clog2(RING_SLOTS + 1);
   localparam int SEQ_W   = srsw_pkg::SEQ_W;
   localparam int TIMER_W = srsw_pkg::TIMER_W;

   // configuration
   logic [srsw_pkg::WSIZE_W-1:0]   window_size_ff;
   logic [srsw_pkg::TIMEOUT_W-1:0] timeout_ticks_ff;
   logic [srsw_pkg::TOTAL_W-1:0]   total_packets_ff;

   // control state
   srsw_pkg::state_type state_ff, state_in;
   logic                cmd_ff, cmd_in;
   logic                ack_good_ff, ack_good_in;
   logic                ack_zero_ff, ack_zero_in;
   logic                term_ff, term_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic [SEQ_W-1:0]    cur_idx_ff, cur_idx_in;
   logic [SLOT_W-1:0]   cur_slot_ff, cur_slot_in;
   logic [SEQ_W-1:0]    base_ff, base_in;
   logic [SLOT_W-1:0]   base_slot_ff, base_slot_in;
   logic                done_ff, done_in;
   logic [N_W-1:0]      slide_n_ff, slide_n_in;
   logic [SLOT_W-1:0]   clr_ff, clr_in;

   // result register
   logic                rsp_valid_ff;
   logic                rsp_kind_ff;
   logic [SEQ_W-1:0]    rsp_seq_num_ff;
   logic [SEQ_W-1:0]    rsp_window_base_ff;
   logic                rsp_finished_ff;
   logic                rsp_last_ff;

   logic                out_load;
   logic                out_kind;
   logic [SEQ_W-1:0]    out_seq;
   logic                out_last;
   logic                out_free;

   // timer RAM ports
   logic                ram_we;
   logic [SLOT_W-1:0]   ram_wa;
   logic [TIMER_W-1:0]  ram_wd;
   logic                ram_re;
   logic [SLOT_W-1:0]   ram_ra;
   logic [TIMER_W-1:0]  ram_rd;

   // derived values
   logic [CNT_W-1:0]    eff_w;
   logic [SEQ_W-1:0]    total_ext;
   logic [SEQ_W-1:0]    ack_diff;
   logic                ack_in_win;
   logic [SLOT_W:0]     mark_sum;
   logic [SLOT_W-1:0]   mark_slot;
   logic                walk_more;

   srsw_ram #(
      .WIDTH (TIMER_W),
      .DEPTH (RING_SLOTS)
   ) u_timer_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_wa),
      .wr_data (ram_wd),
      .rd_en   (ram_re),
      .rd_addr (ram_ra),
      .rd_data (ram_rd)
   );

   function automatic logic [SLOT_W-1:0] slot_next(input logic [SLOT_W-1:0] s);
      logic [SLOT_W-1:0] r;
      if (s == SLOT_W'(RING_SLOTS - 1)) begin
         r = '0;
      end else begin
         r = s + SLOT_W'(1);
      end
      return r;
   endfunction

   assign total_ext = {1'b0, total_packets_ff};

   always_comb begin
      if ({1'b0, window_size_ff} > 7'(WIN_LIM)) begin
         eff_w = CNT_W'(WIN_LIM);
      end else begin
         eff_w = CNT_W'(window_size_ff);
      end
   end

   // ack window check; diff is only meaningful when the ack is at or above base
   assign ack_diff   = cur_idx_ff - base_ff;
   assign ack_in_win = (cur_idx_ff >= base_ff) &&
                       (ack_diff < SEQ_W'(eff_w)) &&
                       (cur_idx_ff <= total_ext);
   assign mark_sum   = {1'b0, base_slot_ff} + {1'b0, ack_diff[SLOT_W-1:0]};
   assign mark_slot  = (mark_sum >= (SLOT_W+1)'(RING_SLOTS)) ?
                       SLOT_W'(mark_sum - (SLOT_W+1)'(RING_SLOTS)) : mark_sum[SLOT_W-1:0];

   assign walk_more  = term_ff ? (cnt_ff == '0)
                               : ((cnt_ff < eff_w) && (cur_idx_ff < total_ext));

   assign out_free   = !rsp_valid_ff || !rsp_stall;

   // configuration port
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         window_size_ff   <= srsw_pkg::WINDOW_SIZE_RST;
         timeout_ticks_ff <= srsw_pkg::TIMEOUT_TICKS_RST;
         total_packets_ff <= srsw_pkg::TOTAL_PACKETS_RST;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            srsw_pkg::CSR_WINDOW_SIZE:   window_size_ff   <= csr_wdata[srsw_pkg::WSIZE_W-1:0];
            srsw_pkg::CSR_TIMEOUT_TICKS: timeout_ticks_ff <= csr_wdata[srsw_pkg::TIMEOUT_W-1:0];
            srsw_pkg::CSR_TOTAL_PACKETS: total_packets_ff <= csr_wdata[srsw_pkg::TOTAL_W-1:0];
            default: ;
         endcase
      end
   end

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= srsw_pkg::ST_CLEAR;
         base_ff      <= '0;
         base_slot_ff <= '0;
         done_ff      <= 1'b0;
         clr_ff       <= '0;
         cnt_ff       <= '0;
         slide_n_ff   <= '0;
         term_ff      <= 1'b0;
         cmd_ff       <= srsw_pkg::CMD_TICK;
         ack_good_ff  <= 1'b0;
         ack_zero_ff  <= 1'b0;
      end else begin
         state_ff     <= state_in;
         base_ff      <= base_in;
         base_slot_ff <= base_slot_in;
         done_ff      <= done_in;
         clr_ff       <= clr_in;
         cnt_ff       <= cnt_in;
         slide_n_ff   <= slide_n_in;
         term_ff      <= term_in;
         cmd_ff       <= cmd_in;
         ack_good_ff  <= ack_good_in;
         ack_zero_ff  <= ack_zero_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_idx_ff  <= cur_idx_in;
      cur_slot_ff <= cur_slot_in;
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      ack_good_in  = ack_good_ff;
      ack_zero_in  = ack_zero_ff;
      term_in      = term_ff;
      cnt_in       = cnt_ff;
      cur_idx_in   = cur_idx_ff;
      cur_slot_in  = cur_slot_ff;
      base_in      = base_ff;
      base_slot_in = base_slot_ff;
      done_in      = done_ff;
      slide_n_in   = slide_n_ff;
      clr_in       = clr_ff;

      ram_we   = 1'b0;
      ram_wa   = cur_slot_ff;
      ram_wd   = srsw_pkg::TIMER_IDLE;
      ram_re   = 1'b0;
      ram_ra   = cur_slot_ff;

      out_load = 1'b0;
      out_kind = srsw_pkg::KIND_STATUS;
      out_seq  = '0;
      out_last = 1'b1;

      unique case (state_ff)
         srsw_pkg::ST_CLEAR: begin
            ram_we = 1'b1;
            ram_wa = clr_ff;
            clr_in = slot_next(clr_ff);
            if (clr_ff == SLOT_W'(RING_SLOTS - 1)) begin
               state_in = srsw_pkg::ST_IDLE;
            end
         end

         srsw_pkg::ST_IDLE: begin
            if (req_valid) begin
               cmd_in      = req_command;
               ack_good_in = req_ack_good;
               ack_zero_in = (req_ack_seq == '0);
               cur_idx_in  = req_ack_seq - SEQ_W'(1);
               state_in    = srsw_pkg::ST_DISPATCH;
            end
         end

         srsw_pkg::ST_DISPATCH: begin
            if (cmd_ff == srsw_pkg::CMD_TICK) begin
               cnt_in      = '0;
               cur_idx_in  = base_ff;
               cur_slot_in = base_slot_ff;
               term_in     = (base_ff == total_ext);
               if (!done_ff && (base_ff <= total_ext)) begin
                  state_in = srsw_pkg::ST_TICK_READ;
               end else begin
                  state_in = srsw_pkg::ST_STATUS;
               end
            end else if (!ack_good_ff) begin
               state_in = srsw_pkg::ST_STATUS;
            end else if (ack_zero_ff) begin
               done_in  = 1'b1;
               state_in = srsw_pkg::ST_STATUS;
            end else begin
               state_in = srsw_pkg::ST_ACK_CHECK;
            end
         end

         srsw_pkg::ST_ACK_CHECK: begin
            slide_n_in = '0;
            if (ack_in_win) begin
               ram_we   = 1'b1;
               ram_wa   = mark_slot;
               ram_wd   = srsw_pkg::TIMER_ACKED;
               state_in = srsw_pkg::ST_SLIDE_READ;
            end else begin
               state_in = srsw_pkg::ST_STATUS;
            end
         end

         srsw_pkg::ST_TICK_READ: begin
            if (walk_more) begin
               ram_re   = 1'b1;
               ram_ra   = cur_slot_ff;
               state_in = srsw_pkg::ST_TICK_EVAL;
            end else begin
               state_in = srsw_pkg::ST_STATUS;
            end
         end

         srsw_pkg::ST_TICK_EVAL: begin
            // holds here while a send result cannot be placed
            if (ram_rd != srsw_pkg::TIMER_IDLE || out_free) begin
               cnt_in      = cnt_ff + CNT_W'(1);
               cur_idx_in  = cur_idx_ff + SEQ_W'(1);
               cur_slot_in = slot_next(cur_slot_ff);
               state_in    = srsw_pkg::ST_TICK_READ;
            end
            if (ram_rd == srsw_pkg::TIMER_IDLE) begin
               if (out_free) begin
                  out_load = 1'b1;
                  out_kind = srsw_pkg::KIND_SEND;
                  out_seq  = cur_idx_ff + SEQ_W'(1);
                  out_last = 1'b0;
                  ram_we   = 1'b1;
                  ram_wd   = {1'b0, timeout_ticks_ff};
               end
            end else if (ram_rd != srsw_pkg::TIMER_ACKED) begin
               ram_we = 1'b1;
               ram_wd = ram_rd - TIMER_W'(1);
            end
         end

         srsw_pkg::ST_SLIDE_READ: begin
            if ((base_ff <= total_ext) && (slide_n_ff < N_W'(RING_SLOTS))) begin
               ram_re   = 1'b1;
               ram_ra   = base_slot_ff;
               state_in = srsw_pkg::ST_SLIDE_EVAL;
            end else begin
               state_in = srsw_pkg::ST_STATUS;
            end
         end

         srsw_pkg::ST_SLIDE_EVAL: begin
            if (ram_rd == srsw_pkg::TIMER_ACKED) begin
               // free the slot for the index one ring later
               ram_we       = 1'b1;
               ram_wa       = base_slot_ff;
               ram_wd       = srsw_pkg::TIMER_IDLE;
               base_in      = base_ff + SEQ_W'(1);
               base_slot_in = slot_next(base_slot_ff);
               slide_n_in   = slide_n_ff + N_W'(1);
               state_in     = srsw_pkg::ST_SLIDE_READ;
            end else begin
               state_in = srsw_pkg::ST_STATUS;
            end
         end

         srsw_pkg::ST_STATUS: begin
            if (out_free) begin
               out_load = 1'b1;
               state_in = srsw_pkg::ST_IDLE;
            end
         end

         default: begin
            state_in = srsw_pkg::ST_IDLE;
         end
      endcase
   end

   assign req_stall = (state_ff != srsw_pkg::ST_IDLE);

   // result register, refilled in the cycle the previous transfer completes
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_kind_ff        <= out_kind;
         rsp_seq_num_ff     <= out_seq;
         rsp_window_base_ff <= base_ff;
         rsp_finished_ff    <= done_ff;
         rsp_last_ff        <= out_last;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_kind        = rsp_kind_ff;
   assign rsp_seq_num     = rsp_seq_num_ff;
   assign rsp_window_base = rsp_window_base_ff;
   assign rsp_finished    = rsp_finished_ff;
   assign rsp_last        = rsp_last_ff;

endmodule

/* rtl/core/srsw_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srsw_checker
// Port-level checks of the sender window block, bound to the top level.
// ----------------------------------------------------------------------------
module srsw_checker (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   input  logic                            req_stall,
   input  logic                            req_command,
   input  logic [srsw_pkg::SEQ_W-1:0]      req_ack_seq,
   input  logic                            req_ack_good,
   input  logic                            rsp_valid,
   input  logic                            rsp_stall,
   input  logic                            rsp_kind,
   input  logic [srsw_pkg::SEQ_W-1:0]      rsp_seq_num,
   input  logic [srsw_pkg::SEQ_W-1:0]      rsp_window_base,
   input  logic                            rsp_finished,
   input  logic                            rsp_last,
   input  logic                            csr_valid,
   input  logic                            csr_ready,
   input  logic [srsw_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [srsw_pkg::CSR_DAT_W-1:0]  csr_wdata
);

   // a stalled result holds until its transfer
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_kind) &&
      $stable(rsp_seq_num) && $stable(rsp_window_base) &&
      $stable(rsp_finished) && $stable(rsp_last))
      else $error("stalled result changed");

   // only the status report closes an item
   a_last_is_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_last == (rsp_kind == srsw_pkg::KIND_STATUS)))
      else $error("last flag does not match result kind");

   // a send request never names a packet below the window base
   a_send_in_window: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_kind == srsw_pkg::KIND_SEND) |->
      (rsp_seq_num > rsp_window_base))
      else $error("send request below window base");

   // one item at a time: busy right after a request transfer
   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request taken while an item is in progress");

endmodule

bind selective_repeat_sender_window_top srsw_checker u_srsw_checker (.*);

/* sim/selective_repeat_sender_window_top_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// selective_repeat_sender_window_top_test
// Self-checking bench for the selective-repeat sender window. A behavioral
// copy of the window bookkeeping predicts every send request and status
// report. Directed rows cover reset, extremes, zero timeout, zero window and
// a shrunken total, then random phases of ticks and acks run under random
// register settings with random gaps and stalls on both channels.
// ----------------------------------------------------------------------------
module selective_repeat_sender_window_top_test;
   import srsw_pkg::*;

   localparam int WINDOW_MAX   = 32;
   localparam int RING_SLOTS   = 64;
   localparam int SEQ_MAX      = 65536;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int DRAIN_CYCLES = 2 * WINDOW_MAX + 8;
   localparam int PHASES       = 6;
   localparam int PHASE_ITEMS  = 25;
   localparam int HOLD_CYCLES  = 300;
   localparam int HOLD_AFTER   = 100;

   typedef struct packed {
      logic             kind;
      logic [SEQ_W-1:0] seq_num;
      logic [SEQ_W-1:0] window_base;
      logic             finished;
      logic             last;
   } window_result_t;

   typedef enum logic [1:0] {ROW_CSR, ROW_ITEM, ROW_KNOWN} row_kind_t;

   typedef struct packed {
      row_kind_t            kind;
      logic [CSR_IDX_W-1:0] csr_idx;
      logic [CSR_DAT_W-1:0] csr_val;
      logic                 cmd;
      logic [SEQ_W-1:0]     seq;
      logic                 good;
      logic                 k_send;
      logic [SEQ_W-1:0]     k_seq;
      logic [SEQ_W-1:0]     k_base;
      logic                 k_fin;
   } stim_row_t;

   logic                 clock;
   logic                 reset        = 1'b1;
   logic                 req_valid    = 1'b0;
   logic                 req_stall;
   logic                 req_command  = CMD_TICK;
   logic [SEQ_W-1:0]     req_ack_seq  = '0;
   logic                 req_ack_good = 1'b0;
   logic                 rsp_valid;
   logic                 rsp_stall    = 1'b0;
   logic                 rsp_kind;
   logic [SEQ_W-1:0]     rsp_seq_num;
   logic [SEQ_W-1:0]     rsp_window_base;
   logic                 rsp_finished;
   logic                 rsp_last;
   logic                 csr_valid    = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index    = CSR_WINDOW_SIZE;
   logic [CSR_DAT_W-1:0] csr_wdata    = '0;

   // shadow of the block state
   logic [TIMER_W-1:0]   model_timer [RING_SLOTS];
   logic [SEQ_W-1:0]     model_base    = '0;
   logic                 model_done    = 1'b0;
   logic [WSIZE_W-1:0]   model_window  = WINDOW_SIZE_RST;
   logic [TIMEOUT_W-1:0] model_timeout = TIMEOUT_TICKS_RST;
   logic [TOTAL_W-1:0]   model_total   = TOTAL_PACKETS_RST;

   window_result_t step_results[$];
   window_result_t awaited_results[$];
   window_result_t oldest_result;
   stim_row_t      directed_rows[$];

   int  errors       = 0;
   int  results_seen = 0;
   int  hold_left    = 0;
   int  cycle_count  = 0;
   bit  held         = 1'b0;
   bit  calm         = 1'b0;

   selective_repeat_sender_window_top #(
      .WINDOW_MAX(WINDOW_MAX),
      .RING_SLOTS(RING_SLOTS)
   ) i_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_command    (req_command),
      .req_ack_seq    (req_ack_seq),
      .req_ack_good   (req_ack_good),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_kind       (rsp_kind),
      .rsp_seq_num    (rsp_seq_num),
      .rsp_window_base(rsp_window_base),
      .rsp_finished   (rsp_finished),
      .rsp_last       (rsp_last),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      foreach (model_timer[i]) model_timer[i] = TIMER_IDLE;
   end

   // ---------------------------------------------------------------- window model

   function automatic int unsigned live_window();
      int unsigned w;
      w = model_window;
      if (w > WINDOW_MAX) w = WINDOW_MAX;
      if (w > RING_SLOTS) w = RING_SLOTS;
      return w;
   endfunction

   function automatic window_result_t result_of(logic kind, logic [SEQ_W-1:0] seq,
                                                logic [SEQ_W-1:0] base, logic fin, logic last);
      window_result_t r;
      r.kind        = kind;
      r.seq_num     = seq;
      r.window_base = base;
      r.finished    = fin;
      r.last        = last;
      return r;
   endfunction

   function automatic void service_slot(int unsigned idx);
      int unsigned s;
      s = idx % RING_SLOTS;
      if (model_timer[s] == TIMER_IDLE) begin
         step_results.push_back(result_of(KIND_SEND, SEQ_W'(idx + 1), model_base, model_done,
                                          1'b0));
         model_timer[s] = {1'b0, model_timeout};
      end else if (model_timer[s] != TIMER_ACKED) begin
         model_timer[s] = model_timer[s] - 1'b1;
      end
   endfunction

   function automatic void predict_window_step(logic cmd, logic [SEQ_W-1:0] ack_seq,
                                               logic good);
      int unsigned w;
      int unsigned base;
      int unsigned total;
      int unsigned idx;
      int unsigned n;
      int unsigned i;
      step_results.delete();
      w     = live_window();
      base  = model_base;
      total = model_total;
      if (cmd == CMD_TICK) begin
         if (!model_done) begin
            if (base < total) begin
               for (i = 0; i < w; i++) begin
                  if (base + i < total) service_slot(base + i);
               end
            end else if (base == total) begin
               // only the terminator is left
               service_slot(total);
            end
         end
      end else if (good) begin
         if (ack_seq == 0) begin
            model_done = 1'b1;
         end else begin
            idx = ack_seq - 1;
            if (idx >= base && idx - base < w && idx <= total) begin
               model_timer[idx % RING_SLOTS] = TIMER_ACKED;
               n = 0;
               while (model_base <= total && n < RING_SLOTS &&
                      model_timer[model_base % RING_SLOTS] == TIMER_ACKED) begin
                  model_timer[model_base % RING_SLOTS] = TIMER_IDLE;
                  model_base++;
                  n++;
               end
            end
         end
      end
      step_results.push_back(result_of(KIND_STATUS, '0, model_base, model_done, 1'b1));
   endfunction

   function automatic void model_config(logic [CSR_IDX_W-1:0] idx, logic [CSR_DAT_W-1:0] val);
      case (idx)
         CSR_WINDOW_SIZE:   model_window  = val[WSIZE_W-1:0];
         CSR_TIMEOUT_TICKS: model_timeout = val[TIMEOUT_W-1:0];
         CSR_TOTAL_PACKETS: model_total   = val[TOTAL_W-1:0];
         default: ;
      endcase
   endfunction

   // ---------------------------------------------------------------- stimulus rows

   function automatic stim_row_t csr_row(logic [CSR_IDX_W-1:0] idx, logic [CSR_DAT_W-1:0] val);
      stim_row_t r;
      r         = '0;
      r.kind    = ROW_CSR;
      r.csr_idx = idx;
      r.csr_val = val;
      return r;
   endfunction

   function automatic stim_row_t item_row(logic cmd, logic [SEQ_W-1:0] seq, logic good);
      stim_row_t r;
      r      = '0;
      r.kind = ROW_ITEM;
      r.cmd  = cmd;
      r.seq  = seq;
      r.good = good;
      return r;
   endfunction

   // known outcome: an optional single send, then the status report
   function automatic stim_row_t known_row(logic cmd, logic [SEQ_W-1:0] seq, logic good,
                                           logic k_send, logic [SEQ_W-1:0] k_seq,
                                           logic [SEQ_W-1:0] k_base, logic k_fin);
      stim_row_t r;
      r        = item_row(cmd, seq, good);
      r.kind   = ROW_KNOWN;
      r.k_send = k_send;
      r.k_seq  = k_seq;
      r.k_base = k_base;
      r.k_fin  = k_fin;
      return r;
   endfunction

   // ---------------------------------------------------------------- drivers

   task automatic send_item(input logic cmd, input logic [SEQ_W-1:0] seq, input logic good,
                            input bit use_model);
      while (!calm && $urandom_range(0, 99) < 36) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid    <= 1'b1;
      req_command  <= cmd;
      req_ack_seq  <= seq;
      req_ack_good <= good;
      do @(posedge clock); while (req_stall);
      predict_window_step(cmd, seq, good);
      if (use_model) begin
         foreach (step_results[i]) awaited_results.push_back(step_results[i]);
      end
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      while (awaited_results.size() != 0) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DAT_W-1:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      do @(posedge clock); while (!csr_ready);
      model_config(idx, val);
   endtask

   task automatic random_config();
      int unsigned pick;
      int unsigned win;
      int unsigned tmo;
      int unsigned total;
      wait_idle();
      pick = $urandom_range(0, 9);
      case (pick)
         0:       win = 0;
         1:       win = 1;
         2:       win = WINDOW_MAX;
         3:       win = $urandom_range(WINDOW_MAX + 1, 63);
         default: win = $urandom_range(2, WINDOW_MAX - 1);
      endcase
      pick = $urandom_range(0, 9);
      case (pick)
         0:       tmo = 0;
         1:       tmo = 255;
         default: tmo = $urandom_range(1, 4);
      endcase
      pick = $urandom_range(0, 9);
      if (pick == 0) total = 65535;
      else if (pick == 1 && model_base > 0) total = $urandom_range(0, model_base - 1);
      else total = model_base + $urandom_range(0, 40);
      write_csr(CSR_WINDOW_SIZE, CSR_DAT_W'(win));
      write_csr(CSR_TIMEOUT_TICKS, CSR_DAT_W'(tmo));
      write_csr(CSR_TOTAL_PACKETS, CSR_DAT_W'(total));
      csr_valid <= 1'b0;
   endtask

   // ticks and acks inside the window, with bad, stray and stale acks mixed in
   task automatic random_phase();
      int unsigned pick;
      int unsigned w;
      int          useful;
      logic [SEQ_W-1:0] seq;
      useful = 0;
      while (useful < PHASE_ITEMS) begin
         pick = $urandom_range(0, 99);
         w    = live_window();
         if (pick < 40) begin
            send_item(CMD_TICK, SEQ_W'($urandom_range(0, SEQ_MAX)), $urandom_range(0, 1), 1'b1);
            useful++;
         end else if (pick < 80) begin
            if (w == 0 || $urandom_range(0, 9) < 6) seq = model_base + 1;
            else seq = model_base + $urandom_range(0, w - 1) + 1;
            send_item(CMD_ACK, seq, 1'b1, 1'b1);
            useful++;
         end else if (pick < 88) begin
            send_item(CMD_ACK, SEQ_W'($urandom_range(0, SEQ_MAX)), 1'b0, 1'b1);
         end else if (pick < 96) begin
            send_item(CMD_ACK, SEQ_W'($urandom_range(1, SEQ_MAX)), 1'b1, 1'b1);
         end else begin
            seq = (model_base > 0) ? SEQ_W'($urandom_range(1, model_base)) : SEQ_W'(1);
            send_item(CMD_ACK, seq, 1'b1, 1'b1);
         end
      end
   endtask

   // ---------------------------------------------------------------- main sequence

   initial begin
      stim_row_t row;
      bit        csr_open;

      // after reset: window 4, timeout 8, one data packet
      directed_rows.push_back(known_row(CMD_TICK, 0, 1'b0, 1'b1, 1, 0, 1'b0));
      directed_rows.push_back(known_row(CMD_TICK, 0, 1'b0, 1'b0, 0, 0, 1'b0));
      directed_rows.push_back(known_row(CMD_ACK, 1, 1'b0, 1'b0, 0, 0, 1'b0));
      directed_rows.push_back(known_row(CMD_ACK, 0, 1'b0, 1'b0, 0, 0, 1'b0));
      // terminator acked ahead of the base, then the base slides past both
      directed_rows.push_back(known_row(CMD_ACK, 2, 1'b1, 1'b0, 0, 0, 1'b0));
      directed_rows.push_back(known_row(CMD_ACK, 1, 1'b1, 1'b0, 0, 2, 1'b0));
      directed_rows.push_back(known_row(CMD_TICK, 0, 1'b0, 1'b0, 0, 2, 1'b0));
      directed_rows.push_back(known_row(CMD_ACK, SEQ_MAX, 1'b1, 1'b0, 0, 2, 1'b0));
      // oversized window clamps, zero timeout resends on every tick
      directed_rows.push_back(csr_row(CSR_WINDOW_SIZE, 63));
      directed_rows.push_back(csr_row(CSR_TIMEOUT_TICKS, 0));
      directed_rows.push_back(csr_row(CSR_TOTAL_PACKETS, 65535));
      directed_rows.push_back(item_row(CMD_TICK, SEQ_MAX, 1'b1));
      directed_rows.push_back(item_row(CMD_TICK, 0, 1'b0));
      // zero window services nothing and ignores numbered acks
      directed_rows.push_back(csr_row(CSR_TIMEOUT_TICKS, 255));
      directed_rows.push_back(csr_row(CSR_WINDOW_SIZE, 0));
      directed_rows.push_back(known_row(CMD_TICK, 0, 1'b0, 1'b0, 0, 2, 1'b0));
      directed_rows.push_back(known_row(CMD_ACK, 3, 1'b1, 1'b0, 0, 2, 1'b0));
      // total shrunk below the base
      directed_rows.push_back(csr_row(CSR_TOTAL_PACKETS, 1));
      directed_rows.push_back(known_row(CMD_TICK, 0, 1'b0, 1'b0, 0, 2, 1'b0));
      // base at the total: only the terminator goes out
      directed_rows.push_back(csr_row(CSR_WINDOW_SIZE, WINDOW_MAX));
      directed_rows.push_back(csr_row(CSR_TOTAL_PACKETS, 2));
      directed_rows.push_back(known_row(CMD_TICK, 0, 1'b0, 1'b1, 3, 2, 1'b0));
      directed_rows.push_back(known_row(CMD_ACK, 3, 1'b1, 1'b0, 0, 3, 1'b0));
      // full window, one tick timeout, acks at the window edges
      directed_rows.push_back(csr_row(CSR_TOTAL_PACKETS, 65535));
      directed_rows.push_back(csr_row(CSR_TIMEOUT_TICKS, 1));
      directed_rows.push_back(item_row(CMD_TICK, 0, 1'b0));
      directed_rows.push_back(item_row(CMD_TICK, 0, 1'b0));
      directed_rows.push_back(item_row(CMD_TICK, 0, 1'b0));
      directed_rows.push_back(item_row(CMD_ACK, 35, 1'b1));
      directed_rows.push_back(item_row(CMD_ACK, 36, 1'b1));
      directed_rows.push_back(item_row(CMD_ACK, 4, 1'b1));
      directed_rows.push_back(item_row(CMD_ACK, 3, 1'b1));
      directed_rows.push_back(item_row(CMD_TICK, 0, 1'b0));
      directed_rows.push_back(item_row(CMD_ACK, 5, 1'b0));

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      csr_open = 1'b0;
      foreach (directed_rows[r]) begin
         row = directed_rows[r];
         if (row.kind == ROW_CSR) begin
            if (!csr_open) begin
               wait_idle();
               csr_open = 1'b1;
            end
            write_csr(row.csr_idx, row.csr_val);
         end else begin
            if (csr_open) begin
               csr_valid <= 1'b0;
               csr_open = 1'b0;
            end
            send_item(row.cmd, row.seq, row.good, row.kind == ROW_ITEM);
            if (row.kind == ROW_KNOWN) begin
               if (row.k_send) begin
                  awaited_results.push_back(result_of(KIND_SEND, row.k_seq, row.k_base,
                                                      row.k_fin, 1'b0));
               end
               awaited_results.push_back(result_of(KIND_STATUS, '0, row.k_base, row.k_fin,
                                                   1'b1));
            end
         end
      end

      for (int p = 0; p < PHASES; p++) begin
         random_config();
         calm = (p == 2);
         random_phase();
      end
      calm = 1'b0;

      // transfer finished: ticks go quiet, acks still slide
      send_item(CMD_ACK, 0, 1'b1, 1'b1);
      send_item(CMD_TICK, 0, 1'b0, 1'b1);
      send_item(CMD_ACK, model_base + 1, 1'b1, 1'b1);
      send_item(CMD_TICK, 0, 1'b1, 1'b1);
      send_item(CMD_ACK, 0, 1'b0, 1'b1);

      wait_idle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (errors == 0 && awaited_results.size() == 0) begin
         $display("selective_repeat_sender_window_top regression: pass");
      end else begin
         $display("selective_repeat_sender_window_top regression: fail");
      end
      $finish;
   end

   // ---------------------------------------------------------------- result side

   function automatic void compare_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         errors++;
      end
   endfunction

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (awaited_results.size() == 0) begin
            $error("unexpected transfer: kind %0d seq_num %0d window_base %0d",
                   rsp_kind, rsp_seq_num, rsp_window_base);
            errors++;
         end else begin
            oldest_result = awaited_results.pop_front();
            compare_field("kind", oldest_result.kind, rsp_kind);
            compare_field("seq_num", oldest_result.seq_num, rsp_seq_num);
            compare_field("window_base", oldest_result.window_base, rsp_window_base);
            compare_field("finished", oldest_result.finished, rsp_finished);
            compare_field("last", oldest_result.last, rsp_last);
         end
         results_seen++;
      end
      // one long hold-off so the block backs up into its request side
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else if (!held && results_seen >= HOLD_AFTER) begin
         held      = 1'b1;
         hold_left = HOLD_CYCLES;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= !calm && ($urandom_range(0, 99) < 36);
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("selective_repeat_sender_window_top regression: fail");
         $finish;
      end
   end

endmodule

/* selective_repeat_sender_window_top.f */
rtl/core/srsw_pkg.sv
rtl/core/srsw_ram.sv
rtl/core/selective_repeat_sender_window_top.sv
rtl/core/srsw_checker.sv
sim/selective_repeat_sender_window_top_test.sv
